// ----- src/mfb_pkg.sv -----
// Shared types, constants and codes for the one-bit framebuffer draw engine.
// No dependencies; every other file but mfb_ram imports this package.
package mfb_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int DEF_MAX_WIDTH  = 800;
    localparam int DEF_MAX_HEIGHT = 480;
    localparam int DEF_ROW_BITS   = 64;

    // Port field widths
    localparam int CMD_W      = 2;
    localparam int COORD_IN_W = 11;
    localparam int DIM_W      = 10;
    localparam int ROWIN_W    = 64;
    localparam int LEN_W      = 7;
    localparam int RADDR_W    = 16;
    localparam int BYTE_W     = 8;

    // Configuration registers
    localparam int WB_W       = 7;
    localparam int HR_W       = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_ROWS = 1'd1;

    localparam logic [WB_W-1:0] WIDTH_BYTES_RESET = 7'd100;
    localparam logic [HR_W-1:0] HEIGHT_ROWS_RESET = 9'd480;

    // Internal widths: clipped coordinates, byte columns, byte addresses
    localparam int COORD_W = 13;
    localparam int BX_W    = 9;
    localparam int TOTAL_W = 16;

    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] PIXEL_MSB = 8'h80;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_GLYPH = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_BASE,
        S_DRAW,
        S_DRAIN,
        S_CLEAR,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               rd_en;
        logic [TOTAL_W-1:0] rd_addr;
        logic               wr_en;
        logic [TOTAL_W-1:0] wr_addr;
        logic [BYTE_W-1:0]  wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              out_of_range;
    } res_t;

endpackage

// ----- src/mfb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48000
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/mfb_seq.sv -----
// Command sequencer: clipping, byte address generation and read-modify-write.
// Depends on mfb_pkg; drives the frame store through a mem_req_t bundle.
module mfb_seq
    import mfb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int ROW_BITS   = DEF_ROW_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [CMD_W-1:0]             command,
    input  logic signed [COORD_IN_W-1:0] x_pos,
    input  logic signed [COORD_IN_W-1:0] y_pos,
    input  logic [DIM_W-1:0]             rect_width,
    input  logic [DIM_W-1:0]             rect_height,
    input  logic [ROWIN_W-1:0]           row_bits,
    input  logic [LEN_W-1:0]             row_length,
    input  logic [RADDR_W-1:0]           read_address,
    input  logic [WB_W-1:0]              width_bytes,
    input  logic [HR_W-1:0]              height_rows,
    output mem_req_t                     mem_req,
    input  logic [BYTE_W-1:0]            rd_data,
    output logic                         res_valid,
    output res_t                         res,
    input  logic                         res_take
);

    localparam int MAX_WB = MAX_WIDTH / 8;
    localparam int GW     = ROW_BITS + 8;

    state_t state_reg, state_next;

    // captured beat
    cmd_t                         cmd_reg;
    logic signed [COORD_IN_W-1:0] x_reg;
    logic signed [COORD_IN_W-1:0] y_reg;
    logic [DIM_W-1:0]             w_reg;
    logic [DIM_W-1:0]             h_reg;
    logic [ROW_BITS-1:0]          bits_reg;
    logic [LEN_W-1:0]             len_reg;
    logic [RADDR_W-1:0]           raddr_reg;

    // working state
    logic [WB_W-1:0]       wb_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    cnt_reg;
    logic [TOTAL_W-1:0]    row_base_reg;
    logic [HR_W-1:0]       row_reg;
    logic [HR_W-1:0]       row_last_reg;
    logic signed [BX_W-1:0] bl_reg;
    logic signed [BX_W-1:0] br_reg;
    logic signed [BX_W-1:0] bx_reg;
    logic [BYTE_W-1:0]     lm_reg;
    logic [BYTE_W-1:0]     rm_reg;
    logic [GW-1:0]         sr_reg;
    logic                  oor_reg;
    res_t                  res_reg;

    // pending write of the RMW pipeline
    logic                  pend_reg;
    logic [TOTAL_W-1:0]    pend_addr_reg;
    logic [BYTE_W-1:0]     pend_mask_reg;

    // setup arithmetic
    logic [WB_W-1:0]          ew;
    logic [HR_W-1:0]          eh;
    logic [TOTAL_W-1:0]       ew_ext;
    logic [TOTAL_W-1:0]       eh_ext;
    logic [TOTAL_W-1:0]       total_c;
    logic signed [COORD_W-1:0] xs, xe, pixlim, xl, xr;
    logic signed [COORD_W-1:0] ys, ye, ylim, yt, yb;
    logic signed [COORD_W-1:0] w_ext, h_ext;
    logic                     fill_empty;
    logic                     glyph_empty;
    logic [LEN_W-1:0]         leng;
    logic [2:0]               off;
    logic [LEN_W:0]           nb_sum;
    logic [3:0]               nb;
    logic [ROW_BITS-1:0]      lenmask;
    logic [ROW_BITS-1:0]      ink;
    logic signed [BX_W-1:0]   bl_glyph;

    // draw datapath
    logic                     col_ok;
    logic [BYTE_W-1:0]        fill_mask;
    logic [BYTE_W-1:0]        byte_mask;
    logic [TOTAL_W-1:0]       draw_addr;
    logic [TOTAL_W-1:0]       row_ext;
    logic                     read_oor;
    logic                     last_byte;

    // panel size saturates at the store geometry
    assign ew     = (int'(width_bytes) > MAX_WB) ? WB_W'(MAX_WB) : width_bytes;
    assign eh     = (int'(height_rows) > MAX_HEIGHT) ? HR_W'(MAX_HEIGHT) : height_rows;
    assign ew_ext = TOTAL_W'(ew);
    assign eh_ext = TOTAL_W'(eh);
    assign total_c = ew_ext * eh_ext;

    // rectangle clip, inclusive bounds
    assign w_ext  = signed'(COORD_W'(w_reg));
    assign h_ext  = signed'(COORD_W'(h_reg));
    assign xs     = COORD_W'(x_reg);
    assign ys     = COORD_W'(y_reg);
    assign xe     = xs + w_ext - 13'sd1;
    assign ye     = ys + h_ext - 13'sd1;
    assign pixlim = signed'(COORD_W'({ew, 3'b000})) - 13'sd1;
    assign ylim   = signed'(COORD_W'(eh)) - 13'sd1;
    assign xl     = xs[COORD_W-1] ? '0 : xs;
    assign yt     = ys[COORD_W-1] ? '0 : ys;
    assign xr     = (xe > pixlim) ? pixlim : xe;
    assign yb     = (ye > ylim) ? ylim : ye;
    assign fill_empty = (w_reg == '0) || (h_reg == '0) || (xr < xl) || (yb < yt);

    // glyph row: ink vector, MSB first, aligned to the byte grid
    assign leng     = (int'(len_reg) > ROW_BITS) ? LEN_W'(ROW_BITS) : len_reg;
    assign off      = x_reg[2:0];
    assign nb_sum   = (LEN_W+1)'(off) + (LEN_W+1)'(leng) + (LEN_W+1)'(7);
    assign nb       = 4'(nb_sum >> 3);
    assign lenmask  = ~({ROW_BITS{1'b1}} >> leng);
    assign ink      = ~bits_reg & lenmask;
    assign bl_glyph = BX_W'(x_reg >>> 3);
    assign glyph_empty = (leng == '0) || ys[COORD_W-1] || (ys > ylim);

    // per-byte mask and address
    assign col_ok    = !bx_reg[BX_W-1] && (bx_reg < signed'(BX_W'(wb_reg)));
    assign fill_mask = ((bx_reg == bl_reg) ? lm_reg : FULL_BYTE)
                     & ((bx_reg == br_reg) ? rm_reg : FULL_BYTE);
    assign byte_mask = (cmd_reg == CMD_GLYPH) ? sr_reg[GW-1 -: BYTE_W] : fill_mask;
    assign draw_addr = row_base_reg + TOTAL_W'(bx_reg[BX_W-2:0]);
    assign row_ext   = TOTAL_W'(row_reg);
    assign read_oor  = (TOTAL_W'(raddr_reg) >= total_reg);
    assign last_byte = (bx_reg == br_reg) && (row_reg == row_last_reg);

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == S_DRAW) && col_ok;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_stall        = 1'b1;
        res_valid       = 1'b0;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = draw_addr;
        // write side of the RMW: read data lands in the cycle after the read
        mem_req.wr_en   = pend_reg;
        mem_req.wr_addr = pend_addr_reg;
        mem_req.wr_data = rd_data & ~pend_mask_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                case (cmd_reg)
                    CMD_CLEAR: state_next = (total_c == '0) ? S_DONE : S_CLEAR;
                    CMD_FILL:  state_next = fill_empty ? S_DONE : S_BASE;
                    CMD_GLYPH: state_next = glyph_empty ? S_DONE : S_BASE;
                    CMD_READ:  state_next = S_READ;
                    default:   state_next = S_DONE;
                endcase
            end
            S_BASE:
            begin
                state_next = S_DRAW;
            end
            S_DRAW:
            begin
                mem_req.rd_en = col_ok;
                if (last_byte)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cnt_reg;
                mem_req.wr_data = FULL_BYTE;
                if (cnt_reg == total_reg - 16'd1)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                mem_req.rd_en   = !read_oor;
                mem_req.rd_addr = TOTAL_W'(raddr_reg);
                state_next      = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= draw_addr;
        pend_mask_reg <= byte_mask;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_reg   <= cmd_t'(command);
                    x_reg     <= x_pos;
                    y_reg     <= y_pos;
                    w_reg     <= rect_width;
                    h_reg     <= rect_height;
                    bits_reg  <= row_bits[ROW_BITS-1:0];
                    len_reg   <= row_length;
                    raddr_reg <= read_address;
                end
            end
            S_PREP:
            begin
                wb_reg    <= ew;
                total_reg <= total_c;
                cnt_reg   <= '0;
                res_reg   <= '0;
                lm_reg    <= FULL_BYTE >> xl[2:0];
                rm_reg    <= BYTE_W'($signed(PIXEL_MSB) >>> xr[2:0]);
                sr_reg    <= {ink, 8'h00} >> off;
                if (cmd_reg == CMD_GLYPH)
                begin
                    row_reg      <= ys[HR_W-1:0];
                    row_last_reg <= ys[HR_W-1:0];
                    bl_reg       <= bl_glyph;
                    bx_reg       <= bl_glyph;
                    br_reg       <= bl_glyph + signed'(BX_W'(nb)) - 9'sd1;
                end
                else
                begin
                    row_reg      <= yt[HR_W-1:0];
                    row_last_reg <= yb[HR_W-1:0];
                    bl_reg       <= BX_W'(xl >>> 3);
                    bx_reg       <= BX_W'(xl >>> 3);
                    br_reg       <= BX_W'(xr >>> 3);
                end
            end
            S_BASE:
            begin
                row_base_reg <= row_ext * TOTAL_W'(wb_reg);
            end
            S_DRAW:
            begin
                if (bx_reg == br_reg)
                begin
                    if (row_reg != row_last_reg)
                    begin
                        row_reg      <= row_reg + 9'd1;
                        bx_reg       <= bl_reg;
                        row_base_reg <= row_base_reg + TOTAL_W'(wb_reg);
                    end
                end
                else
                begin
                    bx_reg <= bx_reg + 9'sd1;
                    sr_reg <= sr_reg << BYTE_W;
                end
            end
            S_CLEAR:
            begin
                cnt_reg <= cnt_reg + 16'd1;
            end
            S_READ:
            begin
                oor_reg <= read_oor;
            end
            S_READ_WAIT:
            begin
                res_reg.read_data    <= oor_reg ? '0 : rd_data;
                res_reg.out_of_range <= oor_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- src/mono_framebuffer_draw_engine_core.sv -----
// One-bit framebuffer draw engine, top level: config registers, frame store, result register.
// Clear writes W*H bytes, fill walks rows * bytes per row, a glyph row the byte columns it
// spans (at most 9); one byte per cycle, set by the frame store's single read-modify-write
// pipeline. Next beat is taken the cycle after a result is handed on.
// Reset idles control, config back to 100 bytes x 480 rows; store is garbage until a clear.
// Depends on mfb_pkg, mfb_ram and mfb_seq.
module mono_framebuffer_draw_engine_core
    import mfb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int ROW_BITS   = DEF_ROW_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // command channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [CMD_W-1:0]             command,
    input  logic signed [COORD_IN_W-1:0] x_pos,
    input  logic signed [COORD_IN_W-1:0] y_pos,
    input  logic [DIM_W-1:0]             rect_width,
    input  logic [DIM_W-1:0]             rect_height,
    input  logic [ROWIN_W-1:0]           row_bits,
    input  logic [LEN_W-1:0]             row_length,
    input  logic [RADDR_W-1:0]           read_address,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [BYTE_W-1:0]            read_data,
    output logic                         out_of_range,
    // configuration writes
    input  logic                         cfg_write_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    // Store is sized for the largest panel; rows are packed at the live width.
    localparam int STORE_BYTES = (MAX_WIDTH / 8) * MAX_HEIGHT;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    logic [WB_W-1:0]   width_bytes_reg;
    logic [HR_W-1:0]   height_rows_reg;

    mem_req_t          mem_req;
    logic [BYTE_W-1:0] ram_rd_data;

    logic              res_valid;
    logic              res_take;
    res_t              res;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] read_data_reg;
    logic              out_of_range_reg;

    // Config: user keeps it only written while idle, unenforced, so no shadowing needed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_bytes_reg <= WIDTH_BYTES_RESET;
            height_rows_reg <= HEIGHT_ROWS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_WIDTH_BYTES: width_bytes_reg <= cfg_data[WB_W-1:0];
                CFG_HEIGHT_ROWS: height_rows_reg <= cfg_data[HR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mfb_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ROW_BITS   (ROW_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .row_bits     (row_bits),
        .row_length   (row_length),
        .read_address (read_address),
        .width_bytes  (width_bytes_reg),
        .height_rows  (height_rows_reg),
        .mem_req      (mem_req),
        .rd_data      (ram_rd_data),
        .res_valid    (res_valid),
        .res          (res),
        .res_take     (res_take)
    );

    // Frame store: one byte per entry, MSB is the leftmost pixel.
    mfb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (AW'(mem_req.wr_addr)),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (AW'(mem_req.rd_addr)),
        .rd_data (ram_rd_data)
    );

    // Result register: decouples the result beat from the next command.
    assign res_take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            read_data_reg    <= res.read_data;
            out_of_range_reg <= res.out_of_range;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign out_of_range = out_of_range_reg;

endmodule

// ----- src/mfb_checker.sv -----
// Port-level checker for the draw engine, bound to the top level.
// Depends on mfb_pkg for field widths.
module mfb_checker
    import mfb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [BYTE_W-1:0] read_data,
    input logic              out_of_range
);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] pend_cnt_reg;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    // commands taken but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= 2'd0;
        end
        else if (in_beat && !out_beat)
        begin
            pend_cnt_reg <= pend_cnt_reg + 2'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pend_cnt_reg <= pend_cnt_reg - 2'd1;
        end
    end

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_cnt_reg != 2'd0)
        else $error("result beat without a command");

    a_bounded_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg != 2'd3)
        else $error("more than two commands outstanding");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> in_stall)
        else $error("command taken while previous one still running");

    a_oor_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> read_data == '0)
        else $error("out-of-range read returned data");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(out_of_range))
        else $error("stalled result beat changed");

endmodule

bind mono_framebuffer_draw_engine_core mfb_checker u_mfb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .out_of_range (out_of_range)
);

// ----- bench/mfb_draw_checker.sv -----
// Checker for the one-bit framebuffer draw engine: watches the command, result and
// register ports, keeps its own panel size and frame store, and checks every result beat.
// Depends on mfb_pkg.
module mfb_draw_checker
    import mfb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int ROW_BITS   = DEF_ROW_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [CMD_W-1:0]             command,
    input  logic signed [COORD_IN_W-1:0] x_pos,
    input  logic signed [COORD_IN_W-1:0] y_pos,
    input  logic [DIM_W-1:0]             rect_width,
    input  logic [DIM_W-1:0]             rect_height,
    input  logic [ROWIN_W-1:0]           row_bits,
    input  logic [LEN_W-1:0]             row_length,
    input  logic [RADDR_W-1:0]           read_address,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [BYTE_W-1:0]            read_data,
    input  logic                         out_of_range,
    input  logic                         cfg_write_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output int                           mismatches,
    output int                           outstanding
);

    localparam int STORE_BYTES = (MAX_WIDTH / 8) * MAX_HEIGHT;

    logic [BYTE_W-1:0] frame_copy [STORE_BYTES];
    logic [WB_W-1:0]   panel_wb;
    logic [HR_W-1:0]   panel_hr;
    res_t              reply_queue [$];

    // register values above the store's size saturate
    function automatic int bytes_across();
        return (panel_wb > MAX_WIDTH / 8) ? MAX_WIDTH / 8 : int'(panel_wb);
    endfunction

    function automatic int rows_down();
        return (panel_hr > MAX_HEIGHT) ? MAX_HEIGHT : int'(panel_hr);
    endfunction

    // black is a 0 bit, MSB is the leftmost pixel; off-panel pixels are dropped
    function automatic void darken(input int px, input int py);
        int idx;
        if (px < 0 || py < 0 || px >= bytes_across() * 8 || py >= rows_down())
            return;
        idx = py * bytes_across() + px / 8;
        if (idx < STORE_BYTES)
            frame_copy[idx] &= ~(PIXEL_MSB >> (px % 8));
    endfunction

    // applies one command to the local frame store and returns its result beat
    function automatic res_t run_command(input cmd_t op, input int x, input int y,
                                         input int w, input int h,
                                         input logic [ROWIN_W-1:0] bits,
                                         input int len, input int addr);
        res_t reply;
        int   total;
        int   x_lo;
        int   x_hi;
        int   y_lo;
        int   y_hi;
        int   i;
        int   j;
        reply = '0;
        total = bytes_across() * rows_down();
        case (op)
            CMD_CLEAR:
                for (i = 0; i < total && i < STORE_BYTES; i++)
                    frame_copy[i] = FULL_BYTE;
            CMD_FILL:
            begin
                // walk the clipped rectangle only
                x_lo = (x < 0) ? 0 : x;
                y_lo = (y < 0) ? 0 : y;
                x_hi = x + w;
                y_hi = y + h;
                if (x_hi > bytes_across() * 8)
                    x_hi = bytes_across() * 8;
                if (y_hi > rows_down())
                    y_hi = rows_down();
                for (j = y_lo; j < y_hi; j++)
                    for (i = x_lo; i < x_hi; i++)
                        darken(i, j);
            end
            CMD_GLYPH:
            begin
                j = (len > ROW_BITS) ? ROW_BITS : len;
                for (i = 0; i < j; i++)
                    if (!bits[ROW_BITS - 1 - i])
                        darken(x + i, y);
            end
            default:
            begin
                if (addr >= total || addr >= STORE_BYTES)
                    reply.out_of_range = 1'b1;
                else
                    reply.read_data = frame_copy[addr];
            end
        endcase
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_ports
        res_t want;
        if (!rst_n)
        begin
            panel_wb = WIDTH_BYTES_RESET;
            panel_hr = HEIGHT_ROWS_RESET;
            reply_queue.delete();
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reply_queue.size() == 0)
                begin
                    $display("%0t: unrequested result beat, read_data %02h out_of_range %0b",
                             $time, read_data, out_of_range);
                    mismatches++;
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %02h, got %02h",
                                 $time, want.read_data, read_data);
                        mismatches++;
                    end
                    if (out_of_range !== want.out_of_range)
                    begin
                        $display("%0t: out_of_range expected %0b, got %0b",
                                 $time, want.out_of_range, out_of_range);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                reply_queue.push_back(run_command(cmd_t'(command), x_pos, y_pos,
                                                  rect_width, rect_height, row_bits,
                                                  row_length, read_address));
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_WIDTH_BYTES: panel_wb = cfg_data[WB_W-1:0];
                    CFG_HEIGHT_ROWS: panel_hr = cfg_data[HR_W-1:0];
                    default: ;
                endcase
            end
            outstanding = reply_queue.size();
        end
    end

endmodule

// ----- bench/tb_mono_framebuffer_draw_engine_core.sv -----
// Testbench top for the one-bit framebuffer draw engine: clock, reset, command stimulus,
// result sink, register writes and the verdict.
// Depends on mfb_pkg, the engine RTL and mfb_draw_checker.
module tb_mono_framebuffer_draw_engine_core;
    import mfb_pkg::*;

    // Longest legal quiet spell is a full 48000-byte clear or fill plus a held-off
    // result; this allows several times that.
    localparam int STALL_LIMIT      = 250000;
    localparam int PHASE_COUNT      = 12;
    localparam int RANDOM_PER_PHASE = 150;
    // idle cycles inserted after the last result before a register write
    localparam int SETTLE_CYCLES    = 8;
    // largest panel (in bytes) on which random clears and wide fills are issued
    localparam int CHEAP_PANEL      = 4096;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [CMD_W-1:0]             command;
    logic signed [COORD_IN_W-1:0] x_pos;
    logic signed [COORD_IN_W-1:0] y_pos;
    logic [DIM_W-1:0]             rect_width;
    logic [DIM_W-1:0]             rect_height;
    logic [ROWIN_W-1:0]           row_bits;
    logic [LEN_W-1:0]             row_length;
    logic [RADDR_W-1:0]           read_address;
    logic                         out_valid;
    logic                         out_stall;
    logic [BYTE_W-1:0]            read_data;
    logic                         out_of_range;
    logic                         cfg_write_en;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    int results_seen = 0;
    bit tx_idle;
    bit rx_idle;

    // Panel settings per phase (width in bytes, height in rows). Minimum, both empty
    // shapes, oversized registers that saturate to the full store, thin strips and a
    // handful of small odd shapes.
    int panel_wb_list [PHASE_COUNT] = '{1, 0, 4, 127, 1, 100, 3, 8, 2, 13, 100, 6};
    int panel_hr_list [PHASE_COUNT] = '{1, 10, 0, 511, 480, 1, 17, 32, 64, 5, 40, 9};

    mono_framebuffer_draw_engine_core i_dut (.*);

    mfb_draw_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result sink. While rx_idle is set, draws a fresh stall count after every accepted result
    // beat; a few times in the run it also holds off for a long stretch so that the engine
    // backs up and stalls its command input while the sender keeps offering.
    initial
    begin : result_sink
        int gap;
        int hold;
        gap       = 0;
        hold      = 0;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else if (gap > 0)
            begin
                out_stall <= 1'b1;
                gap--;
            end
            else
                out_stall <= 1'b0;
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                gap = rx_idle ? $urandom_range(0, 15) : 0;
                if (results_seen % 700 == 350)
                    hold = 400;
            end
        end
    end

    // Watchdog: counts cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one command beat after a random gap and returns at the edge that takes it.
    // Valid is only lowered when there is a gap, so back-to-back beats keep it high.
    task automatic send_beat(input cmd_t c, input int x, input int y, input int w,
                             input int h, input logic [ROWIN_W-1:0] bits,
                             input int len, input int addr);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= c;
        x_pos        <= x[COORD_IN_W-1:0];
        y_pos        <= y[COORD_IN_W-1:0];
        rect_width   <= w[DIM_W-1:0];
        rect_height  <= h[DIM_W-1:0];
        row_bits     <= bits;
        row_length   <= len[LEN_W-1:0];
        read_address <= addr[RADDR_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Fields a command does not use are filled with noise.
    task automatic send_clear();
        send_beat(CMD_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                  {$urandom(), $urandom()}, $urandom(), $urandom());
    endtask

    task automatic send_fill(input int x, input int y, input int w, input int h);
        send_beat(CMD_FILL, x, y, w, h, {$urandom(), $urandom()}, $urandom(), $urandom());
    endtask

    task automatic send_glyph(input int x, input int y, input logic [ROWIN_W-1:0] bits,
                              input int len);
        send_beat(CMD_GLYPH, x, y, $urandom(), $urandom(), bits, len, $urandom());
    endtask

    task automatic send_read(input int addr);
        send_beat(CMD_READ, $urandom(), $urandom(), $urandom(), $urandom(),
                  {$urandom(), $urandom()}, $urandom(), addr);
    endtask

    // Drops valid and waits for every outstanding result to come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Mostly near the panel so that draws land, now and then anywhere in the field.
    function automatic int near_coord(input int span);
        if ($urandom_range(0, 4) == 0)
            return int'($urandom_range(0, 2047)) - 1024;
        return int'($urandom_range(0, span + 16)) - 8;
    endfunction

    initial
    begin
        int p;
        int k;
        int ewb;
        int eh;
        int pw;
        int total;
        int roll;
        int w;
        int h;
        int len;
        logic [ROWIN_W-1:0] bits;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_CLEAR;
        x_pos        = '0;
        y_pos        = '0;
        rect_width   = '0;
        rect_height  = '0;
        row_bits     = '0;
        row_length   = '0;
        read_address = '0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_WIDTH_BYTES;
        cfg_data     = '0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats on the reset panel, 800 x 480. The store is undefined until
        // the first clear, so that comes first.
        send_clear();
        send_read(0);
        send_read(47999);
        send_read(48000);                 // one past the panel
        send_read(65535);
        send_fill(5, 2, 3, 3);            // inside one byte
        send_read(200);
        send_fill(-3, -2, 6, 4);          // clipped top and left
        send_read(0);
        send_fill(-1024, -1024, 1023, 1023);  // ends just short of the panel
        send_fill(1023, 1023, 1023, 1023);
        send_fill(10, 10, 0, 5);          // zero width
        send_fill(10, 10, 5, 0);          // zero height
        send_fill(795, 478, 1023, 1023);  // clipped bottom right corner
        send_read(47899);
        send_read(47999);
        send_glyph(-10, 100, '0, 64);     // solid ink, starts off the left edge
        send_read(10000);
        send_glyph(790, 101, 64'hAAAA_AAAA_AAAA_AAAA, 127);  // length over 64, right clip
        send_read(10199);
        send_glyph(0, 102, '1, 64);       // no ink at all
        send_read(10200);
        send_glyph(16, 103, '0, 0);       // empty row
        send_glyph(3, -1, '0, 20);        // above the panel
        send_glyph(8, 479, 64'h0F0F_0F0F_0F0F_0F0F, 33);
        send_read(47901);

        // Random phases, one panel shape each. Every phase starts with a clear so that
        // nothing reads or modifies bytes the store has not had written.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge clk);
            write_reg(CFG_WIDTH_BYTES, panel_wb_list[p]);
            write_reg(CFG_HEIGHT_ROWS, panel_hr_list[p]);
            ewb   = (panel_wb_list[p] > DEF_MAX_WIDTH / 8) ? DEF_MAX_WIDTH / 8
                                                           : panel_wb_list[p];
            eh    = (panel_hr_list[p] > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : panel_hr_list[p];
            pw    = ewb * 8;
            total = ewb * eh;
            // cycle through both sides idling, one side, the other, and neither
            tx_idle = (p % 4) < 2;
            rx_idle = (p % 4) == 0 || (p % 4) == 2;
            send_clear();

            for (k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                // halfway through, the sender pauses until the engine is empty
                if (k == RANDOM_PER_PHASE / 2)
                    wait_drained();
                roll = $urandom_range(0, 99);
                if (roll < 5 && total <= CHEAP_PANEL)
                    send_clear();
                else if (roll < 35)
                begin
                    // clear and fill run at one byte per cycle, so wide rectangles only
                    // go to small panels
                    if (total > CHEAP_PANEL)
                    begin
                        w = $urandom_range(0, 40);
                        h = $urandom_range(0, 24);
                    end
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        w = $urandom_range(0, 1023);
                        h = $urandom_range(0, 1023);
                    end
                    else
                    begin
                        w = $urandom_range(0, pw + 8);
                        h = $urandom_range(0, eh + 8);
                    end
                    send_fill(near_coord(pw), near_coord(eh), w, h);
                end
                else if (roll < 70)
                begin
                    case ($urandom_range(0, 2))
                        0: bits = {$urandom(), $urandom()};
                        1: bits = {$urandom(), $urandom()} & {$urandom(), $urandom()};
                        default: bits = {$urandom(), $urandom()} | {$urandom(), $urandom()};
                    endcase
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, 64);
                    send_glyph(near_coord(pw), near_coord(eh), bits, len);
                end
                else if (total > 0 && $urandom_range(0, 4) != 0)
                    send_read($urandom_range(0, total - 1));
                else
                    send_read($urandom_range(0, 65535));
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
src/mfb_pkg.sv
src/mfb_ram.sv
src/mfb_seq.sv
src/mono_framebuffer_draw_engine_core.sv
src/mfb_checker.sv
bench/mfb_draw_checker.sv
bench/tb_mono_framebuffer_draw_engine_core.sv
